// ===== hw/rtl/aabb_pair_contact_tracker_core_assert.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef AABB_PAIR_CONTACT_TRACKER_CORE_ASSERT_SVH
`define AABB_PAIR_CONTACT_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define APTC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define APTC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define APTC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define APTC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== hw/rtl/aptc_pkg.sv =====
`timescale 1ns / 1ps
package aptc_pkg;

  localparam int ID_BITS_DEF = 5;
  localparam int IN_ID_W     = 5;
  localparam int POS_W       = 16;
  localparam int SIZE_W      = 15;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_t;

endpackage

// ===== hw/rtl/aptc_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port, registered read data.
module aptc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/aabb_pair_contact_tracker_core.sv =====
`timescale 1ns / 1ps
// Box-pair contact tracker.
// Input: one collider pair per transaction (ids, centres, sizes, dead flags),
// taken at a rising edge where start is high and busy is low.
// Output: one result per transaction, shown for exactly one cycle with
// out_strobe high: the contact event (none/enter/stay/exit) and the current
// overlap bit. The receiver cannot stall; results are never held.
// The accept cycle issues the table read; the next cycle, the work state, takes
// the read data, decides the event, writes the bit back and registers the
// result. Busy stays high in the work state, so a new pair is taken only once
// the block is idle again; the single-port-per-direction touch table sets the pace.
// Touch table: one bit per ordered id pair, 2**(2*ID_BITS) entries in RAM.
// Reset: after rst_n is released the block sweeps all 2**(2*ID_BITS) table
// entries to zero, one entry per cycle, with busy high.
// Pairs with equal ids give no event and leave the table untouched.
`include "aabb_pair_contact_tracker_core_assert.svh"

module aabb_pair_contact_tracker_core #(
  parameter int ID_BITS = aptc_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [aptc_pkg::IN_ID_W-1:0]     in_left_id,
  input  logic [aptc_pkg::IN_ID_W-1:0]     in_right_cid,
  input  logic signed [aptc_pkg::POS_W-1:0] in_left_x,
  input  logic signed [aptc_pkg::POS_W-1:0] in_left_y,
  input  logic signed [aptc_pkg::POS_W-1:0] in_right_x,
  input  logic signed [aptc_pkg::POS_W-1:0] in_right_y,
  input  logic [aptc_pkg::SIZE_W-1:0]      in_left_w,
  input  logic [aptc_pkg::SIZE_W-1:0]      in_left_h,
  input  logic [aptc_pkg::SIZE_W-1:0]      in_right_w,
  input  logic [aptc_pkg::SIZE_W-1:0]      in_right_h,
  input  logic                             in_left_dead,
  input  logic                             in_right_dead,
  output logic                             out_strobe,
  output logic [1:0]                       out_contact_event,
  output logic                             out_overlapping
);

  localparam int ADDR_W   = 2 * ID_BITS;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int ID_EXT_W = (ID_BITS > aptc_pkg::IN_ID_W) ? ID_BITS : aptc_pkg::IN_ID_W;
  localparam int DIFF_W   = aptc_pkg::POS_W + 1;
  localparam int SUM_W    = aptc_pkg::SIZE_W + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WORK
  } state_t;

  // Control
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                out_strobe_r, out_strobe_nxt;

  // Payload held across the table read
  logic [ADDR_W-1:0]        idx_r;
  logic                     same_r;
  logic                     dead_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SUM_W-1:0]         sw_r, sh_r;
  aptc_pkg::contact_event_t ev_r, ev_nxt;
  logic                     ov_r, ov_nxt;

  // Transaction accept and table address
  logic                accept;
  logic [ID_EXT_W-1:0] lid_ext, rid_ext;
  logic [ID_BITS-1:0]  lid, rid;
  logic [ADDR_W-1:0]   rd_addr;

  // Table ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                ram_wdata;
  logic                ram_rdata;

  // Overlap test
  logic [DIFF_W-1:0]   ax_full, ay_full;
  logic [DIFF_W-1:0]   ax2, ay2;
  logic                ov_x, ov_y;

  assign accept  = start && !busy;
  // Ids wider than ID_BITS drop their upper bits; narrower fields zero-extend.
  assign lid_ext = ID_EXT_W'(in_left_id);
  assign rid_ext = ID_EXT_W'(in_right_cid);
  assign lid     = lid_ext[ID_BITS-1:0];
  assign rid     = rid_ext[ID_BITS-1:0];
  assign rd_addr = {lid, rid};

  // 2*|d| < wa + wb on each axis. |d| fits POS_W bits, so 2*|d| fits DIFF_W.
  always_comb begin
    ax_full = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
    ay_full = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
    ax2     = {ax_full[DIFF_W-2:0], 1'b0};
    ay2     = {ay_full[DIFF_W-2:0], 1'b0};
    ov_x    = ax2 < DIFF_W'(sw_r);
    ov_y    = ay2 < DIFF_W'(sh_r);
    ov_nxt  = ov_x && ov_y;
  end

  // Event decision from the table bit read back in the work cycle.
  always_comb begin
    ev_nxt = aptc_pkg::EV_NONE;
    if (!same_r) begin
      priority if (ov_nxt && ram_rdata) begin
        ev_nxt = dead_r ? aptc_pkg::EV_EXIT : aptc_pkg::EV_STAY;
      end else if (ov_nxt) begin
        ev_nxt = dead_r ? aptc_pkg::EV_NONE : aptc_pkg::EV_ENTER;
      end else if (ram_rdata) begin
        ev_nxt = aptc_pkg::EV_EXIT;
      end else begin
        ev_nxt = aptc_pkg::EV_NONE;
      end
    end
  end

  // Table write: zero sweep while clearing, else write back on enter/exit.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      ST_WORK: begin
        ram_we    = (ev_nxt == aptc_pkg::EV_ENTER) || (ev_nxt == aptc_pkg::EV_EXIT);
        ram_wdata = (ev_nxt == aptc_pkg::EV_ENTER);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_strobe_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {ADDR_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // Capture the pair on accept; hold it through the work cycle.
    if (accept) begin
      idx_r  <= rd_addr;
      same_r <= (lid == rid);
      dead_r <= in_left_dead || in_right_dead;
      dx_r   <= DIFF_W'(in_right_x) - DIFF_W'(in_left_x);
      dy_r   <= DIFF_W'(in_right_y) - DIFF_W'(in_left_y);
      sw_r   <= SUM_W'(in_left_w) + SUM_W'(in_right_w);
      sh_r   <= SUM_W'(in_left_h) + SUM_W'(in_right_h);
    end
    if (state_r == ST_WORK) begin
      ev_r <= ev_nxt;
      ov_r <= ov_nxt;
    end
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  aptc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_touch_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_contact_event = ev_r;
  assign out_overlapping   = ov_r;

  // Every work cycle yields exactly one result strobe.
  `APTC_ASSERT_NEXT(a_work_strobe, clk, rst_n, state_r == ST_WORK, out_strobe_r)
  // A strobe is only ever produced by a work cycle.
  `APTC_ASSERT_IMP(a_strobe_src, clk, rst_n, out_strobe_r, $past(state_r) == ST_WORK)
  // Enter and stay require a current overlap.
  `APTC_ASSERT_IMP(a_ev_overlap, clk, rst_n,
    out_strobe_r && (ev_r == aptc_pkg::EV_ENTER || ev_r == aptc_pkg::EV_STAY), ov_r)
  // Equal ids never touch the table.
  `APTC_ASSERT_IMP(a_same_nowrite, clk, rst_n, state_r == ST_WORK && same_r, !ram_we)

endmodule

// ===== tb/aabb_pair_contact_tracker_core_tb.sv =====
`timescale 1ns / 1ps
module aabb_pair_contact_tracker_core_tb;

  localparam int ID_BITS     = aptc_pkg::ID_BITS_DEF;
  localparam int IN_ID_W     = aptc_pkg::IN_ID_W;
  localparam int POS_W       = aptc_pkg::POS_W;
  localparam int SIZE_W      = aptc_pkg::SIZE_W;
  localparam int PAIR_DEPTH  = 1 << (2 * ID_BITS);
  // Longest stretch without a transaction is the table sweep after reset
  // (all PAIR_DEPTH entries) plus the gaps between pairs and the pipeline.
  localparam int IDLE_LIMIT  = 4 * PAIR_DEPTH + 64;
  localparam int RANDOM_PAIRS = 600;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [IN_ID_W-1:0]       left_id;
    logic [IN_ID_W-1:0]       right_cid;
    logic signed [POS_W-1:0]  left_x;
    logic signed [POS_W-1:0]  left_y;
    logic signed [POS_W-1:0]  right_x;
    logic signed [POS_W-1:0]  right_y;
    logic [SIZE_W-1:0]        left_w;
    logic [SIZE_W-1:0]        left_h;
    logic [SIZE_W-1:0]        right_w;
    logic [SIZE_W-1:0]        right_h;
    logic                     left_dead;
    logic                     right_dead;
  } box_pair_t;

  typedef struct {
    aptc_pkg::contact_event_t ev;
    logic                     overlapping;
  } contact_t;

  // Track the touch table and the queue of contact results still owed.
  class contact_event_checker;
    bit       touching [PAIR_DEPTH];
    contact_t pending_contacts [$];
    int       mismatches;

    function new();
      foreach (touching[i]) touching[i] = 1'b0;
      mismatches = 0;
    endfunction

    function bit axis_overlap(logic signed [POS_W-1:0] pa, logic signed [POS_W-1:0] pb,
                              logic [SIZE_W-1:0] sa, logic [SIZE_W-1:0] sb);
      int          d;
      int unsigned ad;
      int unsigned sum;
      d   = int'(pb) - int'(pa);
      ad  = (d < 0) ? -d : d;
      sum = int'(sa) + int'(sb);
      return (ad * 2) < sum;
    endfunction

    function contact_t predict_contact(box_pair_t p);
      contact_t                   c;
      logic [ID_BITS-1:0]         lid;
      logic [ID_BITS-1:0]         rid;
      logic [2*ID_BITS-1:0]       key;
      bit                         dead;
      bit                         prior;
      lid  = p.left_id[ID_BITS-1:0];
      rid  = p.right_cid[ID_BITS-1:0];
      key  = {lid, rid};
      dead = p.left_dead | p.right_dead;
      c.overlapping = axis_overlap(p.left_x, p.right_x, p.left_w, p.right_w) &&
                      axis_overlap(p.left_y, p.right_y, p.left_h, p.right_h);
      c.ev = aptc_pkg::EV_NONE;
      if (lid != rid) begin
        prior = touching[key];
        if (c.overlapping) begin
          if (prior && dead) begin
            c.ev = aptc_pkg::EV_EXIT;
            touching[key] = 1'b0;
          end else if (prior) begin
            c.ev = aptc_pkg::EV_STAY;
          end else if (!dead) begin
            c.ev = aptc_pkg::EV_ENTER;
            touching[key] = 1'b1;
          end
        end else if (prior) begin
          c.ev = aptc_pkg::EV_EXIT;
          touching[key] = 1'b0;
        end
      end
      return c;
    endfunction

    function void note_pair(box_pair_t p);
      pending_contacts.push_back(predict_contact(p));
    endfunction

    function void check_result(logic [1:0] ev, logic overlapping);
      contact_t want;
      if (pending_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: event %0d overlapping %0b", ev, overlapping);
        return;
      end
      want = pending_contacts.pop_front();
      if (ev !== want.ev || overlapping !== want.overlapping) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected event %0d overlapping %0b, got event %0d overlapping %0b",
                   want.ev, want.overlapping, ev, overlapping);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [IN_ID_W-1:0]      in_left_id;
  logic [IN_ID_W-1:0]      in_right_cid;
  logic signed [POS_W-1:0] in_left_x;
  logic signed [POS_W-1:0] in_left_y;
  logic signed [POS_W-1:0] in_right_x;
  logic signed [POS_W-1:0] in_right_y;
  logic [SIZE_W-1:0]       in_left_w;
  logic [SIZE_W-1:0]       in_left_h;
  logic [SIZE_W-1:0]       in_right_w;
  logic [SIZE_W-1:0]       in_right_h;
  logic                    in_left_dead;
  logic                    in_right_dead;
  logic                    out_strobe;
  logic [1:0]              out_contact_event;
  logic                    out_overlapping;

  contact_event_checker checker_h = new();
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;

  always #6 clk = ~clk;

  aabb_pair_contact_tracker_core #(
    .ID_BITS(ID_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_left_id       (in_left_id),
    .in_right_cid     (in_right_cid),
    .in_left_x        (in_left_x),
    .in_left_y        (in_left_y),
    .in_right_x       (in_right_x),
    .in_right_y       (in_right_y),
    .in_left_w        (in_left_w),
    .in_left_h        (in_left_h),
    .in_right_w       (in_right_w),
    .in_right_h       (in_right_h),
    .in_left_dead     (in_left_dead),
    .in_right_dead    (in_right_dead),
    .out_strobe       (out_strobe),
    .out_contact_event(out_contact_event),
    .out_overlapping  (out_overlapping)
  );

  function automatic box_pair_t mk_pair(int lid, int rid, int lx, int ly, int rx, int ry,
                                        int lw, int lh, int rw, int rh, bit ld, bit rd);
    box_pair_t p;
    p.left_id    = lid[IN_ID_W-1:0];
    p.right_cid  = rid[IN_ID_W-1:0];
    p.left_x     = lx[POS_W-1:0];
    p.left_y     = ly[POS_W-1:0];
    p.right_x    = rx[POS_W-1:0];
    p.right_y    = ry[POS_W-1:0];
    p.left_w     = lw[SIZE_W-1:0];
    p.left_h     = lh[SIZE_W-1:0];
    p.right_w    = rw[SIZE_W-1:0];
    p.right_h    = rh[SIZE_W-1:0];
    p.left_dead  = ld;
    p.right_dead = rd;
    return p;
  endfunction

  // Drive a pair; hold it until busy is low after an edge. Lower start only
  // when a gap follows, so start never drops and rises in one time step.
  task automatic send_pair(box_pair_t p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_left_id    <= p.left_id;
    in_right_cid  <= p.right_cid;
    in_left_x     <= p.left_x;
    in_left_y     <= p.left_y;
    in_right_x    <= p.right_x;
    in_right_y    <= p.right_y;
    in_left_w     <= p.left_w;
    in_left_h     <= p.left_h;
    in_right_w    <= p.right_w;
    in_right_h    <= p.right_h;
    in_left_dead  <= p.left_dead;
    in_right_dead <= p.right_dead;
    do @(posedge clk); while (busy);
  endtask

  // Mostly pairs from a small id pool with nearby centres, so contacts enter,
  // stay and exit; the rest is fully random noise over every bit.
  function automatic box_pair_t random_pair(int id_base);
    box_pair_t p;
    int        lx;
    int        ly;
    if ($urandom_range(0, 99) < 15) begin
      p = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      lx = $urandom_range(0, 65535);
      ly = $urandom_range(0, 65535);
      p = mk_pair(id_base + $urandom_range(0, 3), id_base + $urandom_range(0, 3),
                  lx, ly,
                  lx + $urandom_range(0, 512) - 256, ly + $urandom_range(0, 512) - 256,
                  $urandom_range(0, 512), $urandom_range(0, 512),
                  $urandom_range(0, 512), $urandom_range(0, 512),
                  $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    end
    return p;
  endfunction

  // Monitor: record accepted pairs, check results, and watch for a hang.
  always @(posedge clk) begin
    box_pair_t seen;
    if (rst_n) begin
      if (start && !busy) begin
        seen.left_id    = in_left_id;
        seen.right_cid  = in_right_cid;
        seen.left_x     = in_left_x;
        seen.left_y     = in_left_y;
        seen.right_x    = in_right_x;
        seen.right_y    = in_right_y;
        seen.left_w     = in_left_w;
        seen.left_h     = in_left_h;
        seen.right_w    = in_right_w;
        seen.right_h    = in_right_h;
        seen.left_dead  = in_left_dead;
        seen.right_dead = in_right_dead;
        checker_h.note_pair(seen);
      end
      if (out_strobe)
        checker_h.check_result(out_contact_event, out_overlapping);
      if ((start && !busy) || out_strobe)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int id_base;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_left_id    <= '0;
    in_right_cid  <= '0;
    in_left_x     <= '0;
    in_left_y     <= '0;
    in_right_x    <= '0;
    in_right_y    <= '0;
    in_left_w     <= '0;
    in_left_h     <= '0;
    in_right_w    <= '0;
    in_right_h    <= '0;
    in_left_dead  <= 1'b0;
    in_right_dead <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: coordinate and size extremes, the strict compare boundary,
    // zero sizes, every event, dead objects, ordered keys and equal ids.
    send_pair(mk_pair(1, 2, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
    send_pair(mk_pair(1, 2, 32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767, 0, 0));
    send_pair(mk_pair(3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(3, 4, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_pair(mk_pair(5, 6, 0, 0, 10, 0, 10, 8, 10, 8, 0, 0));
    send_pair(mk_pair(5, 6, 0, 0, 10, 0, 10, 8, 11, 8, 0, 0));
    send_pair(mk_pair(5, 6, 0, 0, 10, 0, 10, 8, 11, 8, 0, 0));
    send_pair(mk_pair(6, 5, 0, 0, 10, 0, 10, 8, 11, 8, 0, 0));
    send_pair(mk_pair(5, 6, 0, 0, 10, 0, 10, 8, 10, 8, 0, 0));
    send_pair(mk_pair(6, 5, 0, 0, 0, 0, 32767, 32767, 32767, 32767, 1, 0));
    send_pair(mk_pair(7, 8, 100, 100, 120, 90, 64, 64, 64, 64, 1, 0));
    send_pair(mk_pair(7, 8, 100, 100, 120, 90, 64, 64, 64, 64, 0, 1));
    send_pair(mk_pair(7, 8, 100, 100, 120, 90, 64, 64, 64, 64, 0, 0));
    send_pair(mk_pair(7, 8, 100, 100, 120, 90, 64, 64, 64, 64, 1, 1));
    send_pair(mk_pair(7, 8, 100, 100, 120, 90, 64, 64, 64, 64, 0, 0));
    send_pair(mk_pair(7, 8, 100, 100, 120, 90, 64, 64, 64, 64, 0, 1));
    send_pair(mk_pair(9, 9, 0, 0, 0, 0, 100, 100, 100, 100, 0, 0));
    send_pair(mk_pair(31, 31, 0, 0, 0, 0, 100, 100, 100, 100, 1, 1));
    send_pair(mk_pair(31, 0, -5, -5, 5, 5, 32767, 32767, 0, 0, 0, 0));
    send_pair(mk_pair(0, 31, -5, -5, 5, 5, 32767, 32767, 0, 0, 0, 0));
    send_pair(mk_pair(31, 0, -5, -5, 5, 5, 32767, 32767, 0, 0, 0, 0));
    send_pair(mk_pair(0, 31, 0, -32768, 0, 32767, 4, 32767, 4, 32767, 0, 0));
    send_pair(mk_pair(0, 31, 0, 0, 0, 0, 4, 0, 4, 0, 0, 0));

    // Random: move the id pool and toggle back-to-back bursts now and then.
    id_base = 0;
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 50 == 0) begin
        id_base = $urandom_range(0, 7) * 4;
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      send_pair(random_pair(id_base));
    end
    start <= 1'b0;

    // Drain: wait for every owed result, then a few cycles for strays.
    while (checker_h.pending_contacts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (checker_h.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
